// ===== rtl/average_pool_2d_nhwc_defines.svh =====
// Assertion macros shared by the average pooling checker.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef AVERAGE_POOL_2D_NHWC_DEFINES_SVH
`define AVERAGE_POOL_2D_NHWC_DEFINES_SVH

// same-cycle implication
`define APOOL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APOOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/apool_pkg.sv =====
// Shared types, constants and helpers for the average pooling block.
// No dependencies; used by the block's modules, its checker and its testbench.
package apool_pkg;

    localparam int DEF_MAX_ROWS     = 32;
    localparam int DEF_MAX_COLS     = 32;
    localparam int DEF_MAX_CHANNELS = 32;
    localparam int DEF_MAX_WINDOW   = 8;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_POOL  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        CFG_MAP_HEIGHT      = 3'd0,
        CFG_MAP_WIDTH       = 3'd1,
        CFG_CHANNEL_COUNT   = 3'd2,
        CFG_WINDOW_HEIGHT   = 3'd3,
        CFG_WINDOW_WIDTH    = 3'd4,
        CFG_STEP_SIZE       = 3'd5,
        CFG_PAD_AMOUNT      = 3'd6,
        CFG_AREA_RECIPROCAL = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MULT,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [4:0]         map_row;
        logic [4:0]         map_col;
        logic [4:0]         chan;
        logic signed [15:0] sample;
        logic [4:0]         out_row;
        logic [4:0]         out_col;
    } in_item_t;

    typedef struct packed
    {
        logic signed [15:0] average;
        logic [4:0]         chan_echo;
    } out_item_t;

    typedef struct packed
    {
        cfg_idx_t    index;
        logic [16:0] data;
    } cfg_write_t;

    typedef struct packed
    {
        logic [5:0]  map_height;
        logic [5:0]  map_width;
        logic [5:0]  channel_count;
        logic [3:0]  window_height;
        logic [3:0]  window_width;
        logic [3:0]  step_size;
        logic [2:0]  pad_amount;
        logic [16:0] area_reciprocal;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        map_height:      6'd32,
        map_width:       6'd32,
        channel_count:   6'd32,
        window_height:   4'd2,
        window_width:    4'd2,
        step_size:       4'd2,
        pad_amount:      3'd0,
        area_reciprocal: 17'd16384
    };

    // index width for a count of n, never below one bit
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // signed width of a sum of up to max_window squared Q8.8 samples
    function automatic int sum_bits(input int max_window);
        return 16 + $clog2(max_window * max_window);
    endfunction

endpackage

// ===== rtl/apool_stream_if.sv =====
// Valid/ready channel carrying one packed payload.
// Payload types come from apool_pkg.
interface apool_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/average_pool_2d_nhwc.sv =====
// 2-D average pooling over an NHWC Q8.8 map held in a local single-port-read store.
// A write request (cmd write) goes to the store on acceptance. A pool request steps
// through its window one position per cycle, reading the entries on the map (a zero
// window or a channel outside channel_count or the store skips the scan); the store's
// one read port sets that pace. The result sits in an output register, so the next
// request is taken while it waits. Padding counts in the divisor; the average is
// rounded half up and saturated. The store is not cleared at reset.
// Depends on apool_pkg, apool_stream_if and the apool_* submodules.
module average_pool_2d_nhwc
    import apool_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW
)
(
    input  logic            clk,
    input  logic            rst_n,
    apool_stream_if.sink    cfg,
    apool_stream_if.sink    item,
    apool_stream_if.source  result
);

    localparam int RW    = idx_bits(MAX_ROWS);
    localparam int CW    = idx_bits(MAX_COLS);
    localparam int HW    = idx_bits(MAX_CHANNELS);
    localparam int SUM_W = sum_bits(MAX_WINDOW);

    cfg_t                    cfg_q;
    logic                    wr_en;
    logic [RW-1:0]           wr_row;
    logic [CW-1:0]           wr_col;
    logic [HW-1:0]           wr_chan;
    logic [15:0]             wr_data;
    logic                    rd_en;
    logic [RW-1:0]           rd_row;
    logic [CW-1:0]           rd_col;
    logic [HW-1:0]           rd_chan;
    logic [15:0]             rd_data;
    logic                    scale_start;
    logic signed [SUM_W-1:0] scale_sum;
    logic                    scale_done;
    logic signed [15:0]      scale_avg;

    apool_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    apool_store #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_chan (wr_chan),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .rd_chan (rd_chan),
        .rd_data (rd_data)
    );

    apool_scale #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_scale
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scale_start),
        .sum     (scale_sum),
        .recip   (cfg_q.area_reciprocal),
        .done    (scale_done),
        .average (scale_avg)
    );

    apool_ctrl #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_q       (cfg_q),
        .item        (item),
        .result      (result),
        .wr_en       (wr_en),
        .wr_row      (wr_row),
        .wr_col      (wr_col),
        .wr_chan     (wr_chan),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_row      (rd_row),
        .rd_col      (rd_col),
        .rd_chan     (rd_chan),
        .rd_data     (rd_data),
        .scale_start (scale_start),
        .scale_sum   (scale_sum),
        .scale_done  (scale_done),
        .scale_avg   (scale_avg)
    );

endmodule

// ===== rtl/apool_cfg_regs.sv =====
// Configuration register file, written through its own request channel.
// Depends on apool_pkg and apool_stream_if.
module apool_cfg_regs
    import apool_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    apool_stream_if.sink   cfg,
    output cfg_t           cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_MAP_HEIGHT:      cfg_next.map_height      = cfg.payload.data[5:0];
                CFG_MAP_WIDTH:       cfg_next.map_width       = cfg.payload.data[5:0];
                CFG_CHANNEL_COUNT:   cfg_next.channel_count   = cfg.payload.data[5:0];
                CFG_WINDOW_HEIGHT:   cfg_next.window_height   = cfg.payload.data[3:0];
                CFG_WINDOW_WIDTH:    cfg_next.window_width    = cfg.payload.data[3:0];
                CFG_STEP_SIZE:       cfg_next.step_size       = cfg.payload.data[3:0];
                CFG_PAD_AMOUNT:      cfg_next.pad_amount      = cfg.payload.data[2:0];
                CFG_AREA_RECIPROCAL: cfg_next.area_reciprocal = cfg.payload.data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/apool_store.sv =====
// Tensor store: one write port, one read port, registered read data.
// Depends on apool_pkg; entry (r,c,ch) sits at (r*MAX_COLS + c)*MAX_CHANNELS + ch.
module apool_store
    import apool_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [idx_bits(MAX_ROWS)-1:0]     wr_row,
    input  logic [idx_bits(MAX_COLS)-1:0]     wr_col,
    input  logic [idx_bits(MAX_CHANNELS)-1:0] wr_chan,
    input  logic [15:0]                       wr_data,
    input  logic                              rd_en,
    input  logic [idx_bits(MAX_ROWS)-1:0]     rd_row,
    input  logic [idx_bits(MAX_COLS)-1:0]     rd_col,
    input  logic [idx_bits(MAX_CHANNELS)-1:0] rd_chan,
    output logic [15:0]                       rd_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_CHANNELS;
    localparam int ADDR_W = idx_bits(DEPTH);
    localparam int XW     = ADDR_W + 1;

    logic [15:0]       mem [DEPTH];
    logic [15:0]       rd_data_reg;
    logic [XW-1:0]     wr_lin;
    logic [XW-1:0]     rd_lin;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_lin  = (XW'(wr_row) * XW'(MAX_COLS) + XW'(wr_col)) * XW'(MAX_CHANNELS)
                     + XW'(wr_chan);
    assign rd_lin  = (XW'(rd_row) * XW'(MAX_COLS) + XW'(rd_col)) * XW'(MAX_CHANNELS)
                     + XW'(rd_chan);
    assign wr_addr = wr_lin[ADDR_W-1:0];
    assign rd_addr = rd_lin[ADDR_W-1:0];
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/apool_scale.sv =====
// Two-stage scaler: window sum times Q1.16 reciprocal, round half up, saturate.
// Depends on apool_pkg.
module apool_scale
    import apool_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic signed [sum_bits(MAX_WINDOW)-1:0]   sum,
    input  logic [16:0]                              recip,
    output logic                                     done,
    output logic signed [15:0]                       average
);

    localparam int SUM_W  = sum_bits(MAX_WINDOW);
    localparam int PROD_W = SUM_W + 18;
    localparam int QW     = PROD_W + 1 - 16;
    localparam logic signed [QW-1:0] SAT_MAX = QW'(32767);
    localparam logic signed [QW-1:0] SAT_MIN = QW'(-32768);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_valid_reg;
    logic signed [PROD_W:0]   rnd;
    logic signed [QW-1:0]     quot;
    logic signed [15:0]       avg_reg;
    logic signed [15:0]       avg_next;
    logic                     done_reg;

    assign prod_next = PROD_W'(sum) * PROD_W'($signed({1'b0, recip}));

    // adding half an LSB and flooring gives round to nearest, ties upward
    assign rnd  = $signed({prod_reg[PROD_W-1], prod_reg})
                  + $signed((PROD_W + 1)'(32768));
    assign quot = $signed(rnd[PROD_W:16]);

    always_comb
    begin
        if (quot > SAT_MAX)
        begin
            avg_next = 16'sh7FFF;
        end
        else if (quot < SAT_MIN)
        begin
            avg_next = -16'sh8000;
        end
        else
        begin
            avg_next = quot[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= prod_next;
        end
        if (prod_valid_reg)
        begin
            avg_reg <= avg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= start;
            done_reg       <= prod_valid_reg;
        end
    end

    assign done    = done_reg;
    assign average = avg_reg;

endmodule

// ===== rtl/apool_ctrl.sv =====
// Request sequencer: stores writes, scans the pooling window one position a cycle,
// accumulates, hands the sum to the scaler and holds the result for the sink.
// Depends on apool_pkg and apool_stream_if.
module apool_ctrl
    import apool_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cfg_t                                   cfg_q,
    apool_stream_if.sink                           item,
    apool_stream_if.source                         result,
    output logic                                   wr_en,
    output logic [idx_bits(MAX_ROWS)-1:0]          wr_row,
    output logic [idx_bits(MAX_COLS)-1:0]          wr_col,
    output logic [idx_bits(MAX_CHANNELS)-1:0]      wr_chan,
    output logic [15:0]                            wr_data,
    output logic                                   rd_en,
    output logic [idx_bits(MAX_ROWS)-1:0]          rd_row,
    output logic [idx_bits(MAX_COLS)-1:0]          rd_col,
    output logic [idx_bits(MAX_CHANNELS)-1:0]      rd_chan,
    input  logic [15:0]                            rd_data,
    output logic                                   scale_start,
    output logic signed [sum_bits(MAX_WINDOW)-1:0] scale_sum,
    input  logic                                   scale_done,
    input  logic signed [15:0]                     scale_avg
);

    localparam int RW    = idx_bits(MAX_ROWS);
    localparam int CW    = idx_bits(MAX_COLS);
    localparam int HW    = idx_bits(MAX_CHANNELS);
    localparam int KW    = idx_bits(MAX_WINDOW);
    localparam int SUM_W = sum_bits(MAX_WINDOW);
    localparam int PW    = 12;   // signed window position, covers -7 .. 31*15+7
    localparam int LW    = 5;    // window extent, up to MAX_WINDOW

    state_t                  state_reg;
    state_t                  state_next;
    logic [4:0]              chan_reg;
    logic [4:0]              chan_next;
    logic signed [PW-1:0]    base_r_reg;
    logic signed [PW-1:0]    base_r_next;
    logic signed [PW-1:0]    base_c_reg;
    logic signed [PW-1:0]    base_c_next;
    logic [KW-1:0]           ki_reg;
    logic [KW-1:0]           ki_next;
    logic [KW-1:0]           kj_reg;
    logic [KW-1:0]           kj_next;
    logic                    take_reg;
    logic                    take_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_item_t               out_reg;
    out_item_t               out_next;

    logic                    in_acc;
    logic                    pool_acc;
    logic                    chan_ok;
    logic [LW-1:0]           wh_lim;
    logic [LW-1:0]           ww_lim;
    logic                    win_ok;
    logic [8:0]              org_r;
    logic [8:0]              org_c;
    logic signed [PW-1:0]    pos_r;
    logic signed [PW-1:0]    pos_c;
    logic                    inb;
    logic                    last_col;
    logic                    last_row;
    logic                    out_free;
    logic                    load_out;
    logic                    item_ready;

    // ---------------------------------------------------------------- decode
    assign in_acc   = item.valid && item_ready;
    assign pool_acc = in_acc && (item.payload.cmd == CMD_POOL);

    assign chan_ok = ({1'b0, item.payload.chan} < cfg_q.channel_count)
                     && (int'(item.payload.chan) < MAX_CHANNELS);
    assign wh_lim  = (LW'(cfg_q.window_height) < LW'(MAX_WINDOW))
                     ? LW'(cfg_q.window_height) : LW'(MAX_WINDOW);
    assign ww_lim  = (LW'(cfg_q.window_width) < LW'(MAX_WINDOW))
                     ? LW'(cfg_q.window_width) : LW'(MAX_WINDOW);
    assign win_ok  = (wh_lim != '0) && (ww_lim != '0);

    assign org_r = 9'(item.payload.out_row) * 9'(cfg_q.step_size);
    assign org_c = 9'(item.payload.out_col) * 9'(cfg_q.step_size);

    assign pos_r = base_r_reg + $signed(PW'(ki_reg));
    assign pos_c = base_c_reg + $signed(PW'(kj_reg));

    // padding and the part of the map beyond the store are skipped
    assign inb = (pos_r >= 0) && (pos_r < $signed(PW'(cfg_q.map_height)))
                 && (pos_r < $signed(PW'(MAX_ROWS)))
                 && (pos_c >= 0) && (pos_c < $signed(PW'(cfg_q.map_width)))
                 && (pos_c < $signed(PW'(MAX_COLS)));

    assign last_col = (LW'(kj_reg) == ww_lim - LW'(1));
    assign last_row = (LW'(ki_reg) == wh_lim - LW'(1));
    assign out_free = !out_valid_reg || result.ready;

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pool_acc)
                begin
                    state_next = (chan_ok && win_ok) ? ST_SCAN : ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (last_col && last_row)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_MULT;
            ST_MULT:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (scale_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------ fsm outputs
    always_comb
    begin
        item_ready  = 1'b0;
        rd_en       = 1'b0;
        scale_start = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:   item_ready  = 1'b1;
            ST_SCAN:   rd_en       = inb;
            ST_DRAIN:  item_ready  = 1'b0;
            ST_MULT:   scale_start = 1'b1;
            ST_WAIT:   item_ready  = 1'b0;
            ST_FINISH: load_out    = out_free;
            default:   item_ready  = 1'b0;
        endcase
    end

    assign item.ready = item_ready;

    assign wr_en   = in_acc && (item.payload.cmd == CMD_WRITE)
                     && (int'(item.payload.map_row) < MAX_ROWS)
                     && (int'(item.payload.map_col) < MAX_COLS)
                     && (int'(item.payload.chan) < MAX_CHANNELS);
    assign wr_row  = RW'(item.payload.map_row);
    assign wr_col  = CW'(item.payload.map_col);
    assign wr_chan = HW'(item.payload.chan);
    assign wr_data = item.payload.sample;

    assign rd_row  = RW'(pos_r);
    assign rd_col  = CW'(pos_c);
    assign rd_chan = HW'(chan_reg);

    assign scale_sum = sum_reg;

    // -------------------------------------------------------------- datapath
    always_comb
    begin
        chan_next      = chan_reg;
        base_r_next    = base_r_reg;
        base_c_next    = base_c_reg;
        ki_next        = ki_reg;
        kj_next        = kj_reg;
        take_next      = (state_reg == ST_SCAN) && inb;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (pool_acc)
        begin
            chan_next   = item.payload.chan;
            base_r_next = $signed(PW'(org_r)) - $signed(PW'(cfg_q.pad_amount));
            base_c_next = $signed(PW'(org_c)) - $signed(PW'(cfg_q.pad_amount));
            ki_next     = '0;
            kj_next     = '0;
            sum_next    = '0;
        end

        if (state_reg == ST_SCAN)
        begin
            if (last_col)
            begin
                kj_next = '0;
                ki_next = last_row ? '0 : ki_reg + KW'(1);
            end
            else
            begin
                kj_next = kj_reg + KW'(1);
            end
        end

        // read data of the previous scan cycle lands here
        if (take_reg)
        begin
            sum_next = sum_reg + SUM_W'($signed(rd_data));
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next     = 1'b1;
            out_next.average   = scale_avg;
            out_next.chan_echo = chan_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg   <= chan_next;
        base_r_reg <= base_r_next;
        base_c_reg <= base_c_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ki_reg        <= '0;
            kj_reg        <= '0;
            take_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ki_reg        <= ki_next;
            kj_reg        <= kj_next;
            take_reg      <= take_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// ===== rtl/apool_checker.sv =====
// Port-level checks for average_pool_2d_nhwc, attached by bind.
// Depends on apool_pkg and average_pool_2d_nhwc_defines.svh.
`include "average_pool_2d_nhwc_defines.svh"

module apool_checker
    import apool_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cmd_t               in_cmd,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_average,
    input logic [4:0]         out_chan
);

    `APOOL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `APOOL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_average) && $stable(out_chan), "result changed while stalled")
    `APOOL_ASSERT_NEXT(a_pool_busy, in_valid && in_ready && in_cmd == CMD_POOL, !in_ready, "pool request did not lock the input")
    `APOOL_ASSERT_NEXT(a_write_single, in_valid && in_ready && in_cmd == CMD_WRITE, in_ready, "write request took more than one cycle")
    `APOOL_ASSERT_NOW(a_result_after_pool, $rose(out_valid), !$past(in_ready), "result without a pool request in flight")

endmodule

bind average_pool_2d_nhwc apool_checker u_apool_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .in_cmd      (item.payload.cmd),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_average (result.payload.average),
    .out_chan    (result.payload.chan_echo)
);

// ===== test/average_pool_2d_nhwc_test.sv =====
`timescale 1ns / 1ps
// Testbench for average_pool_2d_nhwc: directed table, then extreme and random settings.
// Every result is checked in order against a hand-worked answer or the pooling model.
// Depends on apool_pkg, apool_stream_if and the RTL of the block.
module average_pool_2d_nhwc_test;
    import apool_pkg::*;

    localparam int STORE_DIM     = 32;
    localparam int WINDOW_LIMIT  = 8;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 64;
    localparam int DIRECTED_ROWS = 39;

    typedef enum logic [1:0]
    {
        ROW_CFG,
        ROW_WRITE,
        ROW_POOL
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t          kind;
        cfg_idx_t           index;
        logic [16:0]        value;   // register data, or the sample of a write
        logic [4:0]         row;     // map row, or output row of a pool
        logic [4:0]         col;
        logic [4:0]         ch;
        logic               typed;   // pool with a hand-worked answer
        logic signed [15:0] want;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // full-scale positive block under the reset settings
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h07FFF, 5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h07FFF, 5'd0,  5'd1,  5'd0,  1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h07FFF, 5'd1,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h07FFF, 5'd1,  5'd1,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd0,  1'b1, 16'sd32767},
        // full-scale negative block in the far corner, last channel
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h08000, 5'd30, 5'd30, 5'd31, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h08000, 5'd30, 5'd31, 5'd31, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h08000, 5'd31, 5'd30, 5'd31, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h08000, 5'd31, 5'd31, 5'd31, 1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd15, 5'd15, 5'd31, 1'b1, 16'sh8000},
        // window wholly off the map
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd31, 5'd31, 5'd31, 1'b1, 16'sd0},
        // single-tap window at one half: rounding ties
        '{ROW_CFG,   CFG_WINDOW_HEIGHT,   17'd1,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_WINDOW_WIDTH,    17'd1,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_STEP_SIZE,       17'd1,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_AREA_RECIPROCAL, 17'd32768, 5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd0,  1'b1, 16'sd16384},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h00001, 5'd0,  5'd0,  5'd1,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd1,  1'b1, 16'sd1},
        '{ROW_WRITE, CFG_MAP_HEIGHT,      17'h0FFFF, 5'd0,  5'd0,  5'd2,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd2,  1'b1, 16'sd0},
        // reciprocal above one saturates both ways
        '{ROW_CFG,   CFG_AREA_RECIPROCAL, 17'h1FFFF, 5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd0,  1'b1, 16'sd32767},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd31, 5'd31, 5'd31, 1'b1, 16'sh8000},
        // channel beyond channel_count
        '{ROW_CFG,   CFG_CHANNEL_COUNT,   17'd1,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd1,  1'b1, 16'sd0},
        // empty window
        '{ROW_CFG,   CFG_WINDOW_HEIGHT,   17'd0,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd0,  1'b1, 16'sd0},
        // oversized window clipped to 8x8
        '{ROW_CFG,   CFG_WINDOW_HEIGHT,   17'd15,    5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_WINDOW_WIDTH,    17'd15,    5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_AREA_RECIPROCAL, 17'd1024,  5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        // zero stride with full padding
        '{ROW_CFG,   CFG_STEP_SIZE,       17'd0,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_PAD_AMOUNT,      17'd7,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd5,  5'd5,  5'd0,  1'b0, 16'sd0},
        // map declared larger than the store
        '{ROW_CFG,   CFG_MAP_HEIGHT,      17'd63,    5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_MAP_WIDTH,       17'd63,    5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_STEP_SIZE,       17'd4,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_CFG,   CFG_PAD_AMOUNT,      17'd0,     5'd0,  5'd0,  5'd0,  1'b0, 16'sd0},
        '{ROW_POOL,  CFG_MAP_HEIGHT,      17'h00000, 5'd7,  5'd7,  5'd0,  1'b0, 16'sd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    apool_stream_if #(.payload_t(cfg_write_t)) cfg_if ();
    apool_stream_if #(.payload_t(in_item_t))   item_if ();
    apool_stream_if #(.payload_t(out_item_t))  result_if ();

    average_pool_2d_nhwc dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .item   (item_if),
        .result (result_if)
    );

    always #5 clk = ~clk;

    // model state: store copy, which entries hold data, and the live settings
    logic signed [15:0] map_copy  [0:STORE_DIM*STORE_DIM*STORE_DIM-1];
    bit                 map_known [0:STORE_DIM*STORE_DIM*STORE_DIM-1];
    cfg_t               shadow_cfg = CFG_RESET;
    out_item_t          awaited_averages [$];
    int                 mismatches = 0;
    int                 items_sent = 0;
    bit                 calm       = 1'b0;
    bit                 cfg_open   = 1'b0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 16'sh7FFF;
        if (roll == 1)
            return 16'sh8000;
        return 16'($urandom);
    endfunction

    // store rows and columns the window touches, clipped to the map
    function automatic void window_bounds(input logic [4:0] ch, orow, ocol,
                                          output bit live, output int rlo, rhi, clo, chi);
        int rows, cols, wh, ww, base_r, base_c;
        rows   = (shadow_cfg.map_height > STORE_DIM) ? STORE_DIM : int'(shadow_cfg.map_height);
        cols   = (shadow_cfg.map_width > STORE_DIM) ? STORE_DIM : int'(shadow_cfg.map_width);
        wh     = (shadow_cfg.window_height > WINDOW_LIMIT) ? WINDOW_LIMIT
                                                           : int'(shadow_cfg.window_height);
        ww     = (shadow_cfg.window_width > WINDOW_LIMIT) ? WINDOW_LIMIT
                                                          : int'(shadow_cfg.window_width);
        base_r = int'(orow) * int'(shadow_cfg.step_size) - int'(shadow_cfg.pad_amount);
        base_c = int'(ocol) * int'(shadow_cfg.step_size) - int'(shadow_cfg.pad_amount);
        live   = (ch < shadow_cfg.channel_count);
        rlo    = (base_r < 0) ? 0 : base_r;
        rhi    = (base_r + wh > rows) ? rows : base_r + wh;
        clo    = (base_c < 0) ? 0 : base_c;
        chi    = (base_c + ww > cols) ? cols : base_c + ww;
    endfunction

    function automatic out_item_t pool_average(input logic [4:0] ch, orow, ocol);
        bit        live;
        int        rlo, rhi, clo, chi;
        longint    acc, scaled;
        out_item_t res;
        window_bounds(ch, orow, ocol, live, rlo, rhi, clo, chi);
        acc    = 0;
        scaled = 0;
        if (live)
        begin
            for (int r = rlo; r < rhi; r++)
                for (int c = clo; c < chi; c++)
                    acc += map_copy[{r[4:0], c[4:0], ch}];
            // round half up, then clamp to Q8.8
            scaled = (acc * longint'(shadow_cfg.area_reciprocal) + 64'sd32768) >>> 16;
            if (scaled > 32767)
                scaled = 32767;
            else if (scaled < -32768)
                scaled = -32768;
        end
        res.average   = scaled[15:0];
        res.chan_echo = ch;
        return res;
    endfunction

    task automatic close_config();
        if (cfg_open)
        begin
            cfg_if.valid <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    task automatic send_item(input in_item_t it, input bit typed,
                             input logic signed [15:0] want);
        int        gap;
        out_item_t res;
        close_config();
        gap = pick_gap();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge clk); while (!item_if.ready);
        items_sent++;
        // accepted: move the model along in request order
        if (it.cmd == CMD_WRITE)
        begin
            map_copy[{it.map_row, it.map_col, it.chan}]  = it.sample;
            map_known[{it.map_row, it.map_col, it.chan}] = 1'b1;
        end
        else
        begin
            res = pool_average(it.chan, it.out_row, it.out_col);
            if (typed)
                res.average = want;
            awaited_averages.push_back(res);
        end
    endtask

    task automatic send_write(input logic [4:0] r, c, ch, input logic signed [15:0] s);
        in_item_t it;
        it         = in_item_t'($urandom);
        it.cmd     = CMD_WRITE;
        it.map_row = r;
        it.map_col = c;
        it.chan    = ch;
        it.sample  = s;
        it.out_row = 5'($urandom);
        it.out_col = 5'($urandom);
        send_item(it, 1'b0, '0);
    endtask

    // entries never written must not be read, so give them data first
    task automatic send_pool(input logic [4:0] ch, orow, ocol, input bit typed,
                             input logic signed [15:0] want);
        bit       live;
        int       rlo, rhi, clo, chi;
        in_item_t it;
        window_bounds(ch, orow, ocol, live, rlo, rhi, clo, chi);
        if (live)
            for (int r = rlo; r < rhi; r++)
                for (int c = clo; c < chi; c++)
                    if (!map_known[{r[4:0], c[4:0], ch}])
                        send_write(r[4:0], c[4:0], ch, pick_sample());
        it         = '0;
        it.cmd     = CMD_POOL;
        it.map_row = 5'($urandom);
        it.map_col = 5'($urandom);
        it.chan    = ch;
        it.sample  = 16'($urandom);
        it.out_row = orow;
        it.out_col = ocol;
        send_item(it, typed, want);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [16:0] value);
        cfg_write_t req;
        req.index      = idx;
        req.data       = value;
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= req;
        cfg_open = 1'b1;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            CFG_MAP_HEIGHT:      shadow_cfg.map_height      = value[5:0];
            CFG_MAP_WIDTH:       shadow_cfg.map_width       = value[5:0];
            CFG_CHANNEL_COUNT:   shadow_cfg.channel_count   = value[5:0];
            CFG_WINDOW_HEIGHT:   shadow_cfg.window_height   = value[3:0];
            CFG_WINDOW_WIDTH:    shadow_cfg.window_width    = value[3:0];
            CFG_STEP_SIZE:       shadow_cfg.step_size       = value[3:0];
            CFG_PAD_AMOUNT:      shadow_cfg.pad_amount      = value[2:0];
            CFG_AREA_RECIPROCAL: shadow_cfg.area_reciprocal = value;
            default: ;
        endcase
    endtask

    // hold the sender until every pool has answered, then let trailing writes finish
    task automatic wait_idle(input int settle);
        item_if.valid <= 1'b0;
        while (awaited_averages.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        int stall;
        stall = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if ($urandom_range(0, 3) == 0)
                stall = pick_gap();
            result_if.ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (awaited_averages.size() == 0)
                report_mismatch($sformatf("unrequested result average %0d chan %0d",
                                          result_if.payload.average,
                                          result_if.payload.chan_echo));
            else
            begin
                want = awaited_averages.pop_front();
                if (result_if.payload.average !== want.average)
                    report_mismatch($sformatf("average %0d, model %0d (chan %0d)",
                                              result_if.payload.average, want.average,
                                              want.chan_echo));
                if (result_if.payload.chan_echo !== want.chan_echo)
                    report_mismatch($sformatf("chan_echo %0d, model %0d",
                                              result_if.payload.chan_echo, want.chan_echo));
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        directed_row_t entry;
        logic [16:0]   regs [8];
        cfg_idx_t      reg_idx;
        int            budget, rows, span_r, span_c, nch, roll, wh, ww, area;
        logic [4:0]    ch;

        cfg_if.valid    <= 1'b0;
        cfg_if.payload  <= '0;
        item_if.valid   <= 1'b0;
        item_if.payload <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            entry = DIRECTED[i];
            case (entry.kind)
                ROW_CFG:
                begin
                    if (!cfg_open)
                        wait_idle(SETTLE_CYCLES);
                    write_register(entry.index, entry.value);
                end
                ROW_WRITE: send_write(entry.row, entry.col, entry.ch, entry.value[15:0]);
                default:   send_pool(entry.ch, entry.row, entry.col, entry.typed, entry.want);
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle(SETTLE_CYCLES);
            calm = ($urandom_range(0, 3) == 0);
            if (p == 0)
            begin
                // every register at the bottom of its field
                foreach (regs[k])
                    regs[k] = '0;
            end
            else if (p == 1)
            begin
                regs[CFG_MAP_HEIGHT]      = 17'd63;
                regs[CFG_MAP_WIDTH]       = 17'd63;
                regs[CFG_CHANNEL_COUNT]   = 17'd63;
                regs[CFG_WINDOW_HEIGHT]   = 17'd15;
                regs[CFG_WINDOW_WIDTH]    = 17'd15;
                regs[CFG_STEP_SIZE]       = 17'd15;
                regs[CFG_PAD_AMOUNT]      = 17'd7;
                regs[CFG_AREA_RECIPROCAL] = 17'h1FFFF;
            end
            else
            begin
                regs[CFG_MAP_HEIGHT]    = 17'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                          : $urandom_range(1, 63));
                regs[CFG_MAP_WIDTH]     = 17'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8)
                                                                          : $urandom_range(1, 63));
                regs[CFG_CHANNEL_COUNT] = 17'(($urandom_range(0, 4) != 0) ? $urandom_range(1, 4)
                                                                          : $urandom_range(0, 63));
                wh = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15);
                ww = ($urandom_range(0, 6) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15);
                regs[CFG_WINDOW_HEIGHT] = 17'(wh);
                regs[CFG_WINDOW_WIDTH]  = 17'(ww);
                regs[CFG_STEP_SIZE]     = 17'(($urandom_range(0, 5) != 0) ? $urandom_range(1, 3)
                                                                          : $urandom_range(0, 15));
                if (wh > 0 && $urandom_range(0, 3) != 0)
                    regs[CFG_PAD_AMOUNT] = 17'($urandom_range(0, (wh > 8) ? 7 : wh - 1));
                else
                    regs[CFG_PAD_AMOUNT] = 17'($urandom_range(0, 7));
                area = ((wh > WINDOW_LIMIT) ? WINDOW_LIMIT : wh)
                     * ((ww > WINDOW_LIMIT) ? WINDOW_LIMIT : ww);
                if (area == 0 || $urandom_range(0, 4) == 0)
                    regs[CFG_AREA_RECIPROCAL] = 17'($urandom_range(0, 131071));
                else
                    regs[CFG_AREA_RECIPROCAL] = 17'((65536 + area / 2) / area);
            end
            reg_idx = reg_idx.first();
            for (int k = 0; k < reg_idx.num(); k++)
            begin
                write_register(reg_idx, regs[reg_idx]);
                reg_idx = reg_idx.next();
            end

            budget = items_sent + ((p < 2) ? 30 : PHASE_ITEMS);
            while (items_sent < budget)
            begin
                roll = $urandom_range(0, 99);
                rows = (shadow_cfg.map_height > STORE_DIM) ? STORE_DIM
                                                           : int'(shadow_cfg.map_height);
                nch  = (shadow_cfg.channel_count > STORE_DIM) ? STORE_DIM
                                                              : int'(shadow_cfg.channel_count);
                if (roll < 55)
                begin
                    // pool whose window lands on the map
                    span_r = (shadow_cfg.step_size == 0) ? 0
                           : (rows + int'(shadow_cfg.pad_amount)) / int'(shadow_cfg.step_size);
                    rows   = (shadow_cfg.map_width > STORE_DIM) ? STORE_DIM
                                                                : int'(shadow_cfg.map_width);
                    span_c = (shadow_cfg.step_size == 0) ? 0
                           : (rows + int'(shadow_cfg.pad_amount)) / int'(shadow_cfg.step_size);
                    span_r = (span_r > 31) ? 31 : span_r;
                    span_c = (span_c > 31) ? 31 : span_c;
                    ch = (nch > 0) ? 5'($urandom_range(0, nch - 1)) : 5'($urandom);
                    send_pool(ch, 5'($urandom_range(0, span_r)), 5'($urandom_range(0, span_c)),
                              1'b0, '0);
                end
                else if (roll < 80)
                    send_write(5'($urandom), 5'($urandom), 5'($urandom), pick_sample());
                else if (roll < 88)
                    send_pool(5'($urandom), 5'($urandom), 5'($urandom), 1'b0, '0);
                else if (roll < 97)
                begin
                    ch = (nch < STORE_DIM) ? 5'($urandom_range(nch, 31)) : 5'($urandom);
                    send_pool(ch, 5'($urandom), 5'($urandom), 1'b0, '0);
                end
                else
                    wait_idle(1);
            end
        end

        wait_idle(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== average_pool_2d_nhwc.f =====
+incdir+rtl
rtl/apool_pkg.sv
rtl/apool_stream_if.sv
rtl/apool_cfg_regs.sv
rtl/apool_store.sv
rtl/apool_scale.sv
rtl/apool_ctrl.sv
rtl/average_pool_2d_nhwc.sv
rtl/apool_checker.sv
test/average_pool_2d_nhwc_test.sv
